[hw/rtl/ppad_pkg.sv]
// ----------------------------------------------------------------------------
// ppad_pkg: shared types and constants for point_pair_angle_degrees
// Holds the arctangent table, the fixed-point layout of the CORDIC datapath
// and the side information that travels with each item down the pipeline.
// ----------------------------------------------------------------------------
package ppad_pkg;

  localparam int unsigned COORD_BITS_DEF      = 16;
  localparam int unsigned ANGLE_FRAC_BITS_DEF = 6;

  localparam int unsigned CORDIC_STEPS = 24;
  // Coordinates are scaled up by this many bits before the first rotation.
  localparam int unsigned PRESCALE     = 24;
  // Headroom for the CORDIC gain and the sign of Y.
  localparam int unsigned GUARD        = 3;
  // Angle accumulator: 2^-20 degree units, signed.
  localparam int unsigned Z_FRAC       = 20;
  localparam int unsigned Z_W          = 28;
  localparam int unsigned Z_MAG_W      = Z_W - 1;

  // atan(2^-i) in units of 2^-20 degree, rounded to nearest.
  localparam logic [Z_MAG_W-1:0] ATAN_TAB [CORDIC_STEPS] = '{
    27'd47185920, 27'd27855475, 27'd14718068, 27'd7471121,
    27'd3750058,  27'd1876857,  27'd938658,   27'd469357,
    27'd234682,   27'd117342,   27'd58671,    27'd29335,
    27'd14668,    27'd7334,     27'd3667,     27'd1833,
    27'd917,      27'd458,      27'd229,      27'd115,
    27'd57,       27'd29,       27'd14,       27'd7
  };

  typedef enum logic [1:0] {
    AXIS_0,
    AXIS_90,
    AXIS_180,
    AXIS_270
  } ppad_axis_e;

  typedef struct packed {
    logic       special;
    logic       dx_neg;
    logic       dy_neg;
    ppad_axis_e axis;
  } ppad_side_t;

endpackage

[hw/rtl/ppad_cordic_stage.sv]
// ----------------------------------------------------------------------------
// ppad_cordic_stage: one vectoring iteration of the arctangent CORDIC
// Rotates (X, Y) toward the positive X axis by atan(2^-STEP), accumulates the
// angle in Z and registers the result with its own valid/ready handshake.
// ----------------------------------------------------------------------------
module ppad_cordic_stage
  import ppad_pkg::*;
#(
  parameter int unsigned W    = 43,
  parameter int unsigned STEP = 0
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                valid_i,
  output logic                ready_o,
  input  logic signed [W-1:0] x_i,
  input  logic signed [W-1:0] y_i,
  input  logic signed [Z_W-1:0] z_i,
  input  ppad_side_t          side_i,
  output logic                valid_o,
  input  logic                ready_i,
  output logic signed [W-1:0] x_o,
  output logic signed [W-1:0] y_o,
  output logic signed [Z_W-1:0] z_o,
  output ppad_side_t          side_o
);

  logic                  valid_q;
  logic signed [W-1:0]   x_d, x_q, y_d, y_q;
  logic signed [Z_W-1:0] z_d, z_q;
  logic signed [W-1:0]   xs, ys;
  logic signed [Z_W-1:0] ang;
  ppad_side_t            side_q;

  assign ready_o = !valid_q || ready_i;

  // Arithmetic shifts round toward minus infinity, as the rotation needs.
  assign xs  = x_i >>> STEP;
  assign ys  = y_i >>> STEP;
  assign ang = $signed({1'b0, ATAN_TAB[STEP]});

  always_comb begin
    if (!y_i[W-1]) begin
      x_d = x_i + ys;
      y_d = y_i - xs;
      z_d = z_i + ang;
    end else begin
      x_d = x_i - ys;
      y_d = y_i + xs;
      z_d = z_i - ang;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      x_q    <= x_d;
      y_q    <= y_d;
      z_q    <= z_d;
      side_q <= side_i;
    end
  end

  assign valid_o = valid_q;
  assign x_o     = x_q;
  assign y_o     = y_q;
  assign z_o     = z_q;
  assign side_o  = side_q;

endmodule

[hw/rtl/point_pair_angle_degrees.sv]
// ----------------------------------------------------------------------------
// point_pair_angle_degrees: direction from a first point to a second point
// Returns atan2(to_y - from_y, to_x - from_x) in degrees within [0, 360), as
// unsigned fixed point with ANGLE_FRAC_BITS fraction bits.
//
//   Channel  Dir  Payload (lowest bits first)
//   s_axis   in   from_x, from_y, to_x, to_y (COORD_BITS each, signed)
//   m_axis   out  direction (9 + ANGLE_FRAC_BITS, unsigned)
//
// One point pair is taken every cycle unless the output stalls; the stages are:
// difference, magnitude and axis check, 24 CORDIC iterations, clamp and round,
// and the quadrant fold into the output register.
// Reset clears the valid bit of every stage; data registers are not reset.
// Each stage has its own ready, so a stall at the output holds every stage in
// place while bubbles ahead of it still close up; nothing is lost or repeated.
// ----------------------------------------------------------------------------
module point_pair_angle_degrees
  import ppad_pkg::*;
#(
  parameter int unsigned COORD_BITS      = COORD_BITS_DEF,
  parameter int unsigned ANGLE_FRAC_BITS = ANGLE_FRAC_BITS_DEF,
  localparam int unsigned IN_W     = ((4 * COORD_BITS + 7) / 8) * 8,
  localparam int unsigned DIR_BITS = 9 + ANGLE_FRAC_BITS,
  localparam int unsigned OUT_W    = ((DIR_BITS + 7) / 8) * 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  input  logic [IN_W-1:0]  s_axis_tdata_i,  // from_x, from_y, to_x, to_y
  output logic             m_axis_tvalid_o,
  input  logic             m_axis_tready_i,
  output logic [OUT_W-1:0] m_axis_tdata_o   // direction
);

  localparam int unsigned CB  = COORD_BITS;
  localparam int unsigned W   = CB + PRESCALE + GUARD;
  localparam int unsigned SH  = Z_FRAC - ANGLE_FRAC_BITS;
  localparam logic [Z_MAG_W-1:0] Z_MAX = Z_MAG_W'(90) << Z_FRAC;
  localparam logic [Z_MAG_W:0]   Z_RND = (Z_MAG_W + 1)'(1) << (SH - 1);
  localparam logic [DIR_BITS-1:0] U90  = DIR_BITS'(90) << ANGLE_FRAC_BITS;
  localparam logic [DIR_BITS-1:0] U180 = DIR_BITS'(180) << ANGLE_FRAC_BITS;
  localparam logic [DIR_BITS-1:0] U270 = DIR_BITS'(270) << ANGLE_FRAC_BITS;
  localparam logic [DIR_BITS-1:0] U360 = DIR_BITS'(360) << ANGLE_FRAC_BITS;

  // Input fields.
  logic [CB-1:0] from_x, from_y, to_x, to_y;
  assign from_x = s_axis_tdata_i[CB-1:0];
  assign from_y = s_axis_tdata_i[2*CB-1:CB];
  assign to_x   = s_axis_tdata_i[3*CB-1:2*CB];
  assign to_y   = s_axis_tdata_i[4*CB-1:3*CB];

  // Stage 0: coordinate differences.
  logic              d_v_q, d_rdy;
  logic signed [CB:0] dx_q, dy_q;

  // Stage 1: magnitudes, scaled, and axis classification.
  logic              p_v_q, p_rdy;
  logic signed [W-1:0] p_x_q, p_y_q;
  ppad_side_t        p_side_d, p_side_q;
  logic signed [CB:0] dx_abs, dy_abs;

  // CORDIC chain.
  logic                  c_v   [CORDIC_STEPS+1];
  logic                  c_rdy [CORDIC_STEPS+1];
  logic signed [W-1:0]   c_x   [CORDIC_STEPS+1];
  logic signed [W-1:0]   c_y   [CORDIC_STEPS+1];
  logic signed [Z_W-1:0] c_z   [CORDIC_STEPS+1];
  ppad_side_t            c_side [CORDIC_STEPS+1];

  // Clamp and round stage.
  logic                r_v_q, r_rdy;
  logic [DIR_BITS-1:0] r_a_d, r_a_q;
  ppad_side_t          r_side_q;
  logic [Z_MAG_W-1:0]  z_clamp;
  logic [Z_MAG_W:0]    z_sum;
  logic signed [Z_W-1:0] z_last;

  // Output register.
  logic                o_v_q, o_rdy;
  logic [DIR_BITS-1:0] o_dir_d, o_dir_q, o_fold;

  // ---------------------------------------------------------------- stage 0
  assign d_rdy           = !d_v_q || p_rdy;
  assign s_axis_tready_o = d_rdy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      d_v_q <= 1'b0;
    end else if (d_rdy) begin
      d_v_q <= s_axis_tvalid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid_i && d_rdy) begin
      dx_q <= $signed({to_x[CB-1], to_x}) - $signed({from_x[CB-1], from_x});
      dy_q <= $signed({to_y[CB-1], to_y}) - $signed({from_y[CB-1], from_y});
    end
  end

  // ---------------------------------------------------------------- stage 1
  assign p_rdy  = !p_v_q || c_rdy[0];
  assign dx_abs = dx_q[CB] ? -dx_q : dx_q;
  assign dy_abs = dy_q[CB] ? -dy_q : dy_q;

  always_comb begin
    p_side_d.dx_neg  = dx_q[CB];
    p_side_d.dy_neg  = dy_q[CB];
    p_side_d.special = (dx_q == '0) || (dy_q == '0);
    if (dx_q == '0) begin
      p_side_d.axis = dy_q[CB] ? AXIS_270 : AXIS_90;
    end else begin
      p_side_d.axis = dx_q[CB] ? AXIS_180 : AXIS_0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p_v_q <= 1'b0;
    end else if (p_rdy) begin
      p_v_q <= d_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (d_v_q && p_rdy) begin
      p_x_q    <= $signed({{GUARD{1'b0}}, dx_abs[CB-1:0], {PRESCALE{1'b0}}});
      p_y_q    <= $signed({{GUARD{1'b0}}, dy_abs[CB-1:0], {PRESCALE{1'b0}}});
      p_side_q <= p_side_d;
    end
  end

  // ------------------------------------------------------------ CORDIC chain
  assign c_v[0]    = p_v_q;
  assign c_x[0]    = p_x_q;
  assign c_y[0]    = p_y_q;
  assign c_z[0]    = '0;
  assign c_side[0] = p_side_q;
  assign c_rdy[CORDIC_STEPS] = r_rdy;

  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_step
    ppad_cordic_stage #(
      .W    (W),
      .STEP (i)
    ) u_step (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (c_v[i]),
      .ready_o (c_rdy[i]),
      .x_i     (c_x[i]),
      .y_i     (c_y[i]),
      .z_i     (c_z[i]),
      .side_i  (c_side[i]),
      .valid_o (c_v[i+1]),
      .ready_i (c_rdy[i+1]),
      .x_o     (c_x[i+1]),
      .y_o     (c_y[i+1]),
      .z_o     (c_z[i+1]),
      .side_o  (c_side[i+1])
    );
  end

  // ------------------------------------------------------- clamp and round
  assign r_rdy  = !r_v_q || o_rdy;
  assign z_last = c_z[CORDIC_STEPS];

  always_comb begin
    if (z_last[Z_W-1]) begin
      z_clamp = '0;
    end else if (z_last[Z_MAG_W-1:0] > Z_MAX) begin
      z_clamp = Z_MAX;
    end else begin
      z_clamp = z_last[Z_MAG_W-1:0];
    end
    z_sum = {1'b0, z_clamp} + Z_RND;
    r_a_d = DIR_BITS'(z_sum >> SH);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      r_v_q <= 1'b0;
    end else if (r_rdy) begin
      r_v_q <= c_v[CORDIC_STEPS];
    end
  end

  always_ff @(posedge clk_i) begin
    if (c_v[CORDIC_STEPS] && r_rdy) begin
      r_a_q    <= r_a_d;
      r_side_q <= c_side[CORDIC_STEPS];
    end
  end

  // --------------------------------------------------------- quadrant fold
  assign o_rdy = !o_v_q || m_axis_tready_i;

  always_comb begin
    if (r_side_q.special) begin
      case (r_side_q.axis)
        AXIS_0:   o_fold = '0;
        AXIS_90:  o_fold = U90;
        AXIS_180: o_fold = U180;
        AXIS_270: o_fold = U270;
        default:  o_fold = '0;
      endcase
    end else if (!r_side_q.dx_neg && !r_side_q.dy_neg) begin
      o_fold = r_a_q;
    end else if (r_side_q.dx_neg && !r_side_q.dy_neg) begin
      o_fold = U180 - r_a_q;
    end else if (r_side_q.dx_neg) begin
      o_fold = U180 + r_a_q;
    end else begin
      o_fold = U360 - r_a_q;
    end
    // A full turn reads as zero.
    o_dir_d = (o_fold >= U360) ? '0 : o_fold;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      o_v_q <= 1'b0;
    end else if (o_rdy) begin
      o_v_q <= r_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (r_v_q && o_rdy) begin
      o_dir_q <= o_dir_d;
    end
  end

  assign m_axis_tvalid_o = o_v_q;
  assign m_axis_tdata_o  = OUT_W'(o_dir_q);

endmodule
